[rtl/buddy_block_allocator_defines.svh]
// ----------------------------------------------------------------------------
// buddy_block_allocator_defines
// Assertion macros for the buddy block allocator.
// ----------------------------------------------------------------------------
// Each macro expects clk in scope; BBA_ASSERT also expects rst_n.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Implication checked on every clock outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked on every clock, reset included.
`define BBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) cond) else $error(msg);

`endif

[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared tag layout and status codes for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Granule tag layout
  localparam int TAG_W     = 7;
  localparam int TAG_START = 6;
  localparam int TAG_FREE  = 5;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [4:0]       order_t;
  typedef logic [1:0]       status_t;

  // Result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_SIZE = 2'd1;
  localparam status_t ST_NO_SPACE = 2'd2;
  localparam status_t ST_BAD_FREE = 2'd3;

  // Request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam int HDR_W     = 7;
  localparam logic [HDR_W-1:0] HDR_RESET = 7'd32;

  function automatic tag_t make_tag(input logic is_free, input order_t ord);
    make_tag = {1'b1, is_free, ord};
  endfunction

endpackage

[rtl/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 2^POOL_EXP byte pool kept as one tag per granule.
// ----------------------------------------------------------------------------
// One request at a time, run by a small sequencer around a two-port tag
// RAM (one read and one write per cycle, registered read). After reset a
// clearing pass over all 2^(POOL_EXP-MIN_EXP) tags (2048 by default) runs
// before a request is taken; configuration writes are taken meanwhile.
// Allocate: decode, a search for the size order, an address-order scan
// that reads the tag of each block visited, then a split down level by
// level. Free: decode, a tag read and check, then a buddy read, check and
// clear per merge level. The tag RAM port sets the pace of scan and merge.
`include "buddy_block_allocator_defines.svh"

module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int POOL_EXP = 16,
  parameter int MIN_EXP  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_data_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_offset,
  output logic [4:0]  out_granted_order
);

  localparam int GW    = POOL_EXP - MIN_EXP;
  localparam int NGRAN = 1 << GW;
  localparam int NW    = (POOL_EXP + 2 > 18) ? POOL_EXP + 2 : 18;

  // Sequencer states
  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DEC      = 4'd2;
  localparam logic [3:0] S_KSRCH    = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_SPLIT    = 4'd6;
  localparam logic [3:0] S_FRD      = 4'd7;
  localparam logic [3:0] S_FCHK     = 4'd8;
  localparam logic [3:0] S_MRG_RD   = 4'd9;
  localparam logic [3:0] S_MRG_CHK  = 4'd10;
  localparam logic [3:0] S_MRG_CLR  = 4'd11;
  localparam logic [3:0] S_FDONE    = 4'd12;

  logic [3:0]      state_r, state_nxt;
  logic [HDR_W-1:0] hdr_r;
  logic            mode_r, mode_nxt;
  logic [16:0]     size_r, size_nxt;
  logic [15:0]     doff_r, doff_nxt;
  logic [4:0]      k_r, k_nxt;
  logic [GW:0]     g_r, g_nxt;
  order_t          ord_r, ord_nxt;
  order_t          freed_r, freed_nxt;
  logic [GW:0]     clr_r, clr_nxt;

  logic            out_valid_r, out_valid_nxt;
  status_t         status_r, status_nxt;
  logic [15:0]     offset_r, offset_nxt;
  order_t          order_r, order_nxt;

  // Tag RAM
  tag_t            mem [NGRAN];
  tag_t            rd_q;
  logic [GW-1:0]   ra, wa;
  tag_t            wd;
  logic            we;

  logic            out_free;
  logic [NW-1:0]   need, kpow, pool_sz, size_ext;
  logic [15:0]     start;
  logic            start_bad;
  logic [GW-1:0]   ga, buddy, half;
  order_t          t_ord;
  logic            t_ok;
  logic [GW:0]     blk_len;
  logic [31:0]     off_full;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Datapath helpers
  assign size_ext = NW'(size_r);
  assign need     = NW'(size_r) + NW'(hdr_r);
  assign kpow     = NW'(1) << k_r;
  assign pool_sz  = NW'(1) << POOL_EXP;
  assign start    = doff_r - 16'(hdr_r);
  assign start_bad = (doff_r < 16'(hdr_r)) || ((32'(start) >> POOL_EXP) != 32'd0) ||
                     (32'(start) & ((32'd1 << MIN_EXP) - 32'd1)) != 32'd0;
  assign ga       = g_r[GW-1:0];
  assign buddy    = ga ^ (GW'(1) << (ord_r - 5'(MIN_EXP)));
  assign half     = GW'(1) << (ord_r - 5'(MIN_EXP) - 5'd1);
  assign t_ord    = rd_q[4:0];
  assign t_ok     = rd_q[TAG_START] && (t_ord >= 5'(MIN_EXP)) && (t_ord <= 5'(POOL_EXP));
  assign blk_len  = (GW+1)'(1) << (t_ord - 5'(MIN_EXP));
  assign off_full = (32'(ga) << MIN_EXP) + 32'(hdr_r);

  // Tag RAM port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    doff_nxt      = doff_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    ord_nxt       = ord_r;
    freed_nxt     = freed_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    offset_nxt    = offset_r;
    order_nxt     = order_r;
    ra            = ga;
    wa            = ga;
    wd            = '0;
    we            = 1'b0;

    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        wa = clr_r[GW-1:0];
        wd = (clr_r == '0) ? make_tag(1'b1, 5'(POOL_EXP)) : '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (GW+1)'(NGRAN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          size_nxt  = in_request_size;
          doff_nxt  = in_data_offset;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (mode_r == MODE_ALLOC) begin
          if (size_r == '0 || size_ext > pool_sz) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_BAD_SIZE;
              offset_nxt    = '0;
              order_nxt     = '0;
              state_nxt     = S_IDLE;
            end
          end else begin
            k_nxt     = 5'(MIN_EXP);
            state_nxt = S_KSRCH;
          end
        end else begin
          if (start_bad) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_BAD_FREE;
              offset_nxt    = '0;
              order_nxt     = '0;
              state_nxt     = S_IDLE;
            end
          end else begin
            g_nxt     = (GW+1)'(32'(start) >> MIN_EXP);
            state_nxt = S_FRD;
          end
        end
      end
      // Smallest order that holds size plus header
      S_KSRCH: begin
        if (k_r > 5'(POOL_EXP)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_NO_SPACE;
            offset_nxt    = '0;
            order_nxt     = '0;
            state_nxt     = S_IDLE;
          end
        end else if (kpow < need) begin
          k_nxt = k_r + 5'd1;
        end else begin
          g_nxt     = '0;
          state_nxt = S_SCAN_RD;
        end
      end
      // Address-order scan for the first free block large enough
      S_SCAN_RD: begin
        if (g_r >= (GW+1)'(NGRAN)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_NO_SPACE;
            offset_nxt    = '0;
            order_nxt     = '0;
            state_nxt     = S_IDLE;
          end
        end else begin
          ra        = ga;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!t_ok) begin
          g_nxt     = g_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else if (rd_q[TAG_FREE] && t_ord >= k_r) begin
          ord_nxt   = t_ord;
          state_nxt = S_SPLIT;
        end else begin
          g_nxt     = g_r + blk_len;
          state_nxt = S_SCAN_RD;
        end
      end
      // Halve down to order k, upper halves become free blocks
      S_SPLIT: begin
        if (ord_r > k_r) begin
          we      = 1'b1;
          wa      = ga + half;
          wd      = make_tag(1'b1, ord_r - 5'd1);
          ord_nxt = ord_r - 5'd1;
        end else if (out_free) begin
          we            = 1'b1;
          wa            = ga;
          wd            = make_tag(1'b0, k_r);
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          offset_nxt    = off_full[15:0];
          order_nxt     = k_r;
          state_nxt     = S_IDLE;
        end
      end
      S_FRD: begin
        ra        = ga;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (!t_ok || rd_q[TAG_FREE]) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_BAD_FREE;
            offset_nxt    = '0;
            order_nxt     = '0;
            state_nxt     = S_IDLE;
          end
        end else begin
          ord_nxt   = t_ord;
          freed_nxt = t_ord;
          state_nxt = S_MRG_RD;
        end
      end
      // Merge with the buddy while it is free and of equal order
      S_MRG_RD: begin
        if (ord_r < 5'(POOL_EXP)) begin
          ra        = buddy;
          state_nxt = S_MRG_CHK;
        end else begin
          state_nxt = S_FDONE;
        end
      end
      S_MRG_CHK: begin
        if (rd_q[TAG_START] && rd_q[TAG_FREE] && t_ord == ord_r) begin
          we        = 1'b1;
          wa        = buddy;
          wd        = '0;
          state_nxt = S_MRG_CLR;
        end else begin
          state_nxt = S_FDONE;
        end
      end
      S_MRG_CLR: begin
        we      = 1'b1;
        wa      = ga;
        wd      = '0;
        ord_nxt = ord_r + 5'd1;
        if (buddy < ga) begin
          g_nxt = {1'b0, buddy};
        end
        state_nxt = S_MRG_RD;
      end
      S_FDONE: begin
        if (out_free) begin
          we            = 1'b1;
          wa            = ga;
          wd            = make_tag(1'b1, ord_r);
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          offset_nxt    = '0;
          order_nxt     = freed_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      hdr_r       <= HDR_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        hdr_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    size_r   <= size_nxt;
    doff_r   <= doff_nxt;
    k_r      <= k_nxt;
    g_r      <= g_nxt;
    ord_r    <= ord_nxt;
    freed_r  <= freed_nxt;
    status_r <= status_nxt;
    offset_r <= offset_nxt;
    order_r  <= order_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_result_offset = offset_r;
  assign out_granted_order = order_r;

  // Checks
  `BBA_ASSERT(a_clr_stalls, (state_r == S_CLR) |-> in_stall, "request taken during clear")
  `BBA_ASSERT(a_mrg_order, (state_r == S_MRG_CHK) |-> (ord_r < 5'(POOL_EXP)), "merge past pool")
  `BBA_ASSERT(a_out_src, $rose(out_valid_r) |-> ($past(state_r) != S_IDLE && $past(state_r) != S_CLR), "result without request")
  `BBA_ASSERT(a_split_order, (state_r == S_SPLIT) |-> (ord_r >= k_r), "split below order")

endmodule

[sim/bba_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches the request and result channels of the buddy allocator, keeps its
// own copy of the granule tags and header size, predicts each result and
// compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
#(
  parameter int POOL_EXP = 16,
  parameter int MIN_EXP  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [16:0] in_request_size,
  input  logic [15:0] in_data_offset,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_result_offset,
  input  logic [4:0]  out_granted_order,
  output int          fail_count,
  output int          pending
);

  localparam int NUM_GRAN = 1 << (POOL_EXP - MIN_EXP);

  typedef struct packed {
    status_t     status;
    logic [15:0] offset;
    order_t      order;
  } alloc_result_t;

  tag_t            gran_tag [NUM_GRAN];
  logic [HDR_W-1:0] hdr_bytes;
  alloc_result_t   expected_q[$];

  function automatic alloc_result_t bad(input status_t st);
    alloc_result_t r;
    r.status = st;
    r.offset = '0;
    r.order  = '0;
    return r;
  endfunction

  // Allocate: first fitting free block in address order, then split down
  function automatic alloc_result_t model_alloc(input logic [16:0] sz);
    alloc_result_t r;
    int need, k, g, o;
    tag_t t;
    logic found;
    found = 1'b0;
    o = 0;
    if (sz == 0 || sz > (1 << POOL_EXP)) return bad(ST_BAD_SIZE);
    need = sz + hdr_bytes;
    k = MIN_EXP;
    while (k <= POOL_EXP && (1 << k) < need) k++;
    if (k > POOL_EXP) return bad(ST_NO_SPACE);
    g = 0;
    while (g < NUM_GRAN) begin
      t = gran_tag[g];
      o = t[4:0];
      if (!t[TAG_START] || o < MIN_EXP || o > POOL_EXP) begin
        g++;
      end else if (t[TAG_FREE] && o >= k) begin
        found = 1'b1;
        break;
      end else begin
        g += 1 << (o - MIN_EXP);
      end
    end
    if (!found) return bad(ST_NO_SPACE);
    while (o > k) begin
      o--;
      gran_tag[g + (1 << (o - MIN_EXP))] = {2'b11, order_t'(o)};
    end
    gran_tag[g] = {2'b10, order_t'(k)};
    r.status = ST_OK;
    r.offset = 16'((g << MIN_EXP) + hdr_bytes);
    r.order  = order_t'(k);
    return r;
  endfunction

  // Free: validate the block start, then merge with free buddies upward
  function automatic alloc_result_t model_free(input logic [15:0] doff);
    alloc_result_t r;
    int start, g, o, b;
    tag_t t, bt;
    if (doff < hdr_bytes) return bad(ST_BAD_FREE);
    start = doff - hdr_bytes;
    if ((start >> POOL_EXP) != 0 || (start & ((1 << MIN_EXP) - 1)) != 0)
      return bad(ST_BAD_FREE);
    g = start >> MIN_EXP;
    t = gran_tag[g];
    o = t[4:0];
    if (!t[TAG_START] || t[TAG_FREE] || o < MIN_EXP || o > POOL_EXP)
      return bad(ST_BAD_FREE);
    r.status = ST_OK;
    r.offset = '0;
    r.order  = order_t'(o);
    while (o < POOL_EXP) begin
      b = g ^ (1 << (o - MIN_EXP));
      bt = gran_tag[b];
      if (!bt[TAG_START] || !bt[TAG_FREE] || bt[4:0] != o) break;
      gran_tag[b] = '0;
      gran_tag[g] = '0;
      if (b < g) g = b;
      o++;
    end
    gran_tag[g] = {2'b11, order_t'(o)};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      foreach (gran_tag[i]) gran_tag[i] = '0;
      gran_tag[0] = {2'b11, order_t'(POOL_EXP)};
      hdr_bytes = HDR_RESET;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) hdr_bytes = cfg_wr_data;
      // Compare returned result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("results outstanding", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_status != want.status)
            report_mismatch("status", out_status, want.status);
          if (out_result_offset != want.offset)
            report_mismatch("result_offset", out_result_offset, want.offset);
          if (out_granted_order != want.order)
            report_mismatch("granted_order", out_granted_order, want.order);
        end
      end
      // Predict for each accepted request
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_FREE) expected_q.push_back(model_free(in_data_offset));
        else                      expected_q.push_back(model_alloc(in_request_size));
      end
    end
  end

endmodule

[sim/tb_buddy_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Drives allocate and free requests into the buddy allocator under several
// header sizes and idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
  import bba_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [16:0] in_request_size;
  logic [15:0] in_data_offset;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_result_offset;
  logic [4:0]  out_granted_order;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  logic [6:0]  cur_hdr;
  logic [15:0] live_offsets[$];
  logic        sent_modes[$];
  logic [15:0] last_freed;

  buddy_block_allocator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_request_size  (in_request_size),
    .in_data_offset   (in_data_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_offset(out_result_offset),
    .out_granted_order(out_granted_order)
  );

  bba_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_request_size  (in_request_size),
    .in_data_offset   (in_data_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_offset(out_result_offset),
    .out_granted_order(out_granted_order),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #300ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver stall: random, or a long hold-off when requested
  initial hold_left = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Track granted offsets so frees can target live blocks
  always @(posedge clk) begin
    logic m;
    if (rst_n) begin
      if (out_valid && !out_stall && sent_modes.size() > 0) begin
        m = sent_modes.pop_front();
        if (m == MODE_ALLOC && out_status == ST_OK) live_offsets.push_back(out_result_offset);
      end
      if (in_valid && !in_stall) sent_modes.push_back(in_mode);
    end
  end

  task automatic send_req(input logic mode, input logic [16:0] sz, input logic [15:0] doff);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_request_size <= sz;
    in_data_offset  <= doff;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Header change between phases; live offsets move with the header
  task automatic set_header(input logic [6:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    foreach (live_offsets[i]) live_offsets[i] = live_offsets[i] - cur_hdr + v;
    cur_hdr = v;
  endtask

  task automatic send_alloc(input logic [16:0] sz);
    send_req(MODE_ALLOC, sz, 16'($urandom));
  endtask

  task automatic send_free(input logic [15:0] doff);
    send_req(MODE_FREE, 17'($urandom), doff);
  endtask

  // Random mix: mostly sensible allocate/free traffic, some noise
  task automatic random_traffic(input int count);
    int r, idx, free_pct;
    for (int n = 0; n < count; n++) begin
      free_pct = (live_offsets.size() > 40) ? 70 : 45;
      if (live_offsets.size() > 0 && $urandom_range(99) < free_pct) begin
        r = $urandom_range(99);
        if (r < 80) begin
          idx = $urandom_range(live_offsets.size() - 1);
          last_freed = live_offsets[idx];
          live_offsets.delete(idx);
          send_free(last_freed);
        end else if (r < 88) send_free(16'($urandom));
        else if (r < 94) send_free(16'(($urandom_range(2047) << 5) + cur_hdr));
        else send_free(last_freed);
      end else begin
        r = $urandom_range(99);
        if (r < 60)      send_alloc(17'($urandom_range(1, 256)));
        else if (r < 85) send_alloc(17'($urandom_range(257, 4096)));
        else if (r < 95) send_alloc(17'($urandom_range(4097, 65536)));
        else             send_alloc(17'($urandom_range(0, 131071)));
      end
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_ALLOC;
    in_request_size <= '0;
    in_data_offset  <= '0;
    out_stall       <= 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    cur_hdr         = HDR_RESET;
    last_freed      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size extremes, bad frees, whole pool grant
    send_alloc(17'd0);
    send_alloc(17'd65536);
    send_alloc(17'd65537);
    send_alloc(17'h1FFFF);
    send_alloc(17'd1);
    drain();
    last_freed = live_offsets.pop_front();
    send_free(last_freed);
    send_free(last_freed);
    send_free(16'd0);
    send_free(16'd33);
    send_free(16'hFFFF);
    send_alloc(17'd65504);
    send_alloc(17'd1);
    drain();
    last_freed = live_offsets.pop_front();
    send_free(last_freed);
    set_header(7'd0);
    send_alloc(17'd65536);
    send_alloc(17'd32);
    drain();
    last_freed = live_offsets.pop_front();
    send_free(last_freed);
    send_alloc(17'd33);
    send_alloc(17'd1);
    send_free(16'd0);

    // No idling, with a long receiver hold-off to back up the input
    set_header(7'd32);
    @(posedge clk);
    hold_left <= 600;
    random_traffic(375);

    set_header(7'd0);
    send_idle_pct = 84;
    random_traffic(375);

    set_header(7'd64);
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    random_traffic(375);

    set_header(7'($urandom_range(1, 63)));
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    random_traffic(375);

    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/bba_pkg.sv
rtl/buddy_block_allocator.sv
sim/bba_checker.sv
sim/tb_buddy_block_allocator.sv
